>>> hw/rtl/avcc_anxb_pkg.sv
// ----------------------------------------------------------------------------
// avcc_anxb_pkg: shared constants and helpers for the length-prefix converter
// Widths of the channel payloads, start-code bytes and saturating counters.
// ----------------------------------------------------------------------------
package avcc_anxb_pkg;

	localparam int unsigned PacketSizeBits = 24;
	localparam int unsigned WrittenBits    = 26;
	localparam int unsigned LenBits        = 32;
	localparam int unsigned NlsBits        = 3;
	localparam int unsigned ByteBits       = 8;
	localparam int unsigned BeatCntBits    = 3;

	localparam logic [NlsBits-1:0] NlsReset = 3'd4;
	localparam logic [NlsBits-1:0] NlsMin   = 3'd1;
	localparam logic [NlsBits-1:0] NlsMax   = 3'd4;
	localparam logic [NlsBits-1:0] SeenMax  = 3'd7;

	localparam logic [ByteBits-1:0] StartCodeZero = 8'h00;
	localparam logic [ByteBits-1:0] StartCodeLast = 8'h01;

	localparam logic [BeatCntBits-1:0] SingleBeat     = 3'd1;
	localparam logic [BeatCntBits-1:0] StartCodeBeats = 3'd4;
	localparam logic [BeatCntBits-1:0] NextToLastBeat = 3'd2;

	// A NAL that ends with this many packet bytes or fewer left ends the packet.
	localparam logic [PacketSizeBits-1:0] TailDropMax = PacketSizeBits'(2);

	localparam logic [WrittenBits-1:0] WrittenMax = '1;

	// Saturating add of a small count to the emitted-byte counter.
	function automatic logic [WrittenBits-1:0] sat_add(
		input logic [WrittenBits-1:0] value,
		input logic [BeatCntBits-1:0] inc
	);
		logic [WrittenBits:0] sum;
		sum = {1'b0, value} + (WrittenBits + 1)'(inc);
		return (sum > {1'b0, WrittenMax}) ? WrittenMax : sum[WrittenBits-1:0];
	endfunction

endpackage

>>> hw/rtl/avcc_anxb_pkt_if.sv
// ----------------------------------------------------------------------------
// avcc_anxb_pkt_if: packet byte channel
// One length-prefixed packet byte per beat, with start flag and packet size.
// ----------------------------------------------------------------------------
interface avcc_anxb_pkt_if;
	logic                                      valid;
	logic                                      ready;
	logic [avcc_anxb_pkg::ByteBits-1:0]        data_byte;
	logic                                      packet_start;
	logic [avcc_anxb_pkg::PacketSizeBits-1:0]  packet_size;

	modport source(output valid, data_byte, packet_start, packet_size, input ready);
	modport sink(input valid, data_byte, packet_start, packet_size, output ready);
endinterface

>>> hw/rtl/avcc_anxb_nal_if.sv
// ----------------------------------------------------------------------------
// avcc_anxb_nal_if: converted stream channel
// One start-code or payload byte per beat, with packet end, error and count.
// ----------------------------------------------------------------------------
interface avcc_anxb_nal_if;
	logic                                    valid;
	logic                                    ready;
	logic [avcc_anxb_pkg::ByteBits-1:0]      out_byte;
	logic                                    end_of_packet;
	logic                                    error_flag;
	logic [avcc_anxb_pkg::WrittenBits-1:0]   written_total;

	modport source(output valid, out_byte, end_of_packet, error_flag, written_total,
		input ready);
	modport sink(input valid, out_byte, end_of_packet, error_flag, written_total,
		output ready);
endinterface

>>> hw/rtl/avcc_anxb_cfg_if.sv
// ----------------------------------------------------------------------------
// avcc_anxb_cfg_if: configuration write channel
// Carries the NAL length prefix size register write.
// ----------------------------------------------------------------------------
interface avcc_anxb_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [avcc_anxb_pkg::NlsBits-1:0]   prefix_size;

	modport source(output valid, prefix_size, input ready);
	modport sink(input valid, prefix_size, output ready);
endinterface

>>> hw/rtl/avcc_to_annexb_nal_stream.sv
// ----------------------------------------------------------------------------
// avcc_to_annexb_nal_stream: H.264 length-prefixed to Annex B converter
// Rewrites NAL length prefixes into 00 00 00 01 start codes, byte by byte.
// ----------------------------------------------------------------------------
// The block takes one packet byte per cycle on pkt while nal is ready and no
// start code is pending. A byte flagged with packet_start begins a packet of
// packet_size bytes and restarts conversion. Each NAL length prefix
// (prefix_size bytes, big-endian, 1 to 4; values 0 and 5..7 act as 1 and 4)
// is collected; a valid length produces four beats of start code on nal,
// after which payload bytes pass one for one. An empty packet, a zero length,
// a length past the end of the packet, or a packet that ends inside a prefix
// produces a single error beat (out_byte 0, error_flag and end_of_packet
// set) and the rest of the packet is swallowed. When a NAL ends with two or
// fewer packet bytes left, its last payload beat carries end_of_packet and
// the trailing bytes are dropped. The byte that completes a good prefix holds
// the input, since the single result register drains its four start-code
// beats before the next byte enters. A new byte is taken in the same cycle the
// last pending beat leaves. Results are registered and appear in the cycle
// after the byte that caused them. The configuration register may only be
// written while no packet is in flight; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module avcc_to_annexb_nal_stream (
	input  logic                    clk,
	input  logic                    arst_n,
	avcc_anxb_pkt_if.sink           pkt,
	avcc_anxb_nal_if.source         nal,
	avcc_anxb_cfg_if.sink           cfg
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_PREFIX,
		PH_PAYLOAD,
		PH_DROP
	} phase_t;

	// Converter state.
	phase_t                                        phase_q;
	logic [avcc_anxb_pkg::PacketSizeBits-1:0]      bytes_left_q;
	logic [avcc_anxb_pkg::LenBits-1:0]             len_acc_q;
	logic [avcc_anxb_pkg::NlsBits-1:0]             seen_q;
	logic [avcc_anxb_pkg::LenBits-1:0]             payload_left_q;
	logic [avcc_anxb_pkg::WrittenBits-1:0]         written_q;
	logic [avcc_anxb_pkg::NlsBits-1:0]             nls_q;

	// Result register. For a start code burst, the count holds the beats
	// still to go, including the one on the port.
	logic                                          out_valid_q;
	logic [avcc_anxb_pkg::BeatCntBits-1:0]         out_cnt_q;
	logic                                          out_sc_q;
	logic [avcc_anxb_pkg::ByteBits-1:0]            out_byte_q;
	logic                                          out_eop_q;
	logic                                          out_err_q;
	logic [avcc_anxb_pkg::WrittenBits-1:0]         out_written_q;

	// Next-state and result of the byte on the input.
	phase_t                                        ph_d;
	logic [avcc_anxb_pkg::PacketSizeBits-1:0]      bl_d;
	logic [avcc_anxb_pkg::LenBits-1:0]             acc_d;
	logic [avcc_anxb_pkg::NlsBits-1:0]             seen_d;
	logic [avcc_anxb_pkg::LenBits-1:0]             pl_d;
	logic [avcc_anxb_pkg::WrittenBits-1:0]         bw_d;
	logic [avcc_anxb_pkg::BeatCntBits-1:0]         res_cnt;
	logic                                          res_sc;
	logic [avcc_anxb_pkg::ByteBits-1:0]            res_byte;
	logic                                          res_eop;
	logic                                          res_err;
	logic [avcc_anxb_pkg::WrittenBits-1:0]         res_written;
	logic                                          done;

	logic [avcc_anxb_pkg::NlsBits-1:0]             nls_eff;
	logic                                          take;
	logic                                          last_beat;
	logic                                          accept;

	// Out-of-range register values are clamped to the legal 1..4.
	assign nls_eff = (nls_q < avcc_anxb_pkg::NlsMin) ? avcc_anxb_pkg::NlsMin :
		(nls_q > avcc_anxb_pkg::NlsMax) ? avcc_anxb_pkg::NlsMax : nls_q;

	// The input is free when the result register is empty or its final beat
	// is leaving in this cycle.
	assign take      = nal.valid && nal.ready;
	assign last_beat = (out_cnt_q == avcc_anxb_pkg::SingleBeat);
	assign pkt.ready = !out_valid_q || (take && last_beat);
	assign accept    = pkt.valid && pkt.ready;
	assign cfg.ready = 1'b1;

	assign nal.valid         = out_valid_q;
	assign nal.out_byte      = out_byte_q;
	assign nal.end_of_packet = out_eop_q;
	assign nal.error_flag    = out_err_q;
	assign nal.written_total = out_written_q;

	// One byte of conversion: packet restart, then prefix collection, payload
	// copy or dropping, depending on the phase.
	always_comb begin
		ph_d        = phase_q;
		bl_d        = bytes_left_q;
		acc_d       = len_acc_q;
		seen_d      = seen_q;
		pl_d        = payload_left_q;
		bw_d        = written_q;
		res_cnt     = '0;
		res_sc      = 1'b0;
		res_byte    = avcc_anxb_pkg::StartCodeZero;
		res_eop     = 1'b0;
		res_err     = 1'b0;
		res_written = written_q;
		done        = 1'b0;

		if (pkt.packet_start) begin
			bl_d   = pkt.packet_size;
			bw_d   = '0;
			acc_d  = '0;
			seen_d = '0;
			pl_d   = '0;
			if (pkt.packet_size == '0) begin
				// An empty packet is an error straight away.
				ph_d        = PH_IDLE;
				res_cnt     = avcc_anxb_pkg::SingleBeat;
				res_eop     = 1'b1;
				res_err     = 1'b1;
				res_written = '0;
				done        = 1'b1;
			end else begin
				ph_d = PH_PREFIX;
			end
		end

		if (!done) begin
			if (ph_d == PH_IDLE || bl_d == '0) begin
				ph_d = PH_IDLE;
			end else begin
				bl_d = bl_d - 1'b1;
				unique case (ph_d)
					PH_PREFIX: begin
						acc_d = {acc_d[avcc_anxb_pkg::LenBits-avcc_anxb_pkg::ByteBits-1:0],
							pkt.data_byte};
						if (seen_d != avcc_anxb_pkg::SeenMax) begin
							seen_d = seen_d + 1'b1;
						end
						if (seen_d >= nls_eff) begin
							if (acc_d == '0 || acc_d > avcc_anxb_pkg::LenBits'(bl_d)) begin
								res_cnt     = avcc_anxb_pkg::SingleBeat;
								res_eop     = 1'b1;
								res_err     = 1'b1;
								res_written = bw_d;
								ph_d        = (bl_d != '0) ? PH_DROP : PH_IDLE;
							end else begin
								pl_d        = acc_d;
								ph_d        = PH_PAYLOAD;
								res_cnt     = avcc_anxb_pkg::StartCodeBeats;
								res_sc      = 1'b1;
								res_written = avcc_anxb_pkg::sat_add(bw_d,
									avcc_anxb_pkg::SingleBeat);
								bw_d        = avcc_anxb_pkg::sat_add(bw_d,
									avcc_anxb_pkg::StartCodeBeats);
							end
						end else if (bl_d == '0) begin
							// The packet ended inside a prefix.
							res_cnt     = avcc_anxb_pkg::SingleBeat;
							res_eop     = 1'b1;
							res_err     = 1'b1;
							res_written = bw_d;
							ph_d        = PH_IDLE;
						end
					end
					PH_PAYLOAD: begin
						bw_d = avcc_anxb_pkg::sat_add(bw_d, avcc_anxb_pkg::SingleBeat);
						if (pl_d != '0) begin
							pl_d = pl_d - 1'b1;
						end
						res_cnt     = avcc_anxb_pkg::SingleBeat;
						res_byte    = pkt.data_byte;
						res_written = bw_d;
						if (pl_d == '0) begin
							if (bl_d <= avcc_anxb_pkg::TailDropMax) begin
								res_eop = 1'b1;
								ph_d    = (bl_d != '0) ? PH_DROP : PH_IDLE;
							end else begin
								ph_d   = PH_PREFIX;
								seen_d = '0;
								acc_d  = '0;
							end
						end
					end
					PH_DROP: begin
						if (bl_d == '0) begin
							ph_d = PH_IDLE;
						end
					end
					default: begin
						ph_d = PH_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			bytes_left_q   <= '0;
			len_acc_q      <= '0;
			seen_q         <= '0;
			payload_left_q <= '0;
			written_q      <= '0;
			nls_q          <= avcc_anxb_pkg::NlsReset;
			out_valid_q    <= 1'b0;
			out_cnt_q      <= '0;
			out_sc_q       <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				nls_q <= cfg.prefix_size;
			end
			if (accept) begin
				phase_q        <= ph_d;
				bytes_left_q   <= bl_d;
				len_acc_q      <= acc_d;
				seen_q         <= seen_d;
				payload_left_q <= pl_d;
				written_q      <= bw_d;
				out_valid_q    <= (res_cnt != '0);
				out_cnt_q      <= res_cnt;
				out_sc_q       <= res_sc;
				out_byte_q     <= res_byte;
				out_eop_q      <= res_eop;
				out_err_q      <= res_err;
				out_written_q  <= res_written;
			end else if (take) begin
				if (last_beat) begin
					out_valid_q <= 1'b0;
					out_cnt_q   <= '0;
				end else begin
					// Next start code beat: the final one carries 01.
					out_cnt_q     <= out_cnt_q - 1'b1;
					out_byte_q    <= (out_cnt_q == avcc_anxb_pkg::NextToLastBeat) ?
						avcc_anxb_pkg::StartCodeLast : avcc_anxb_pkg::StartCodeZero;
					out_written_q <= avcc_anxb_pkg::sat_add(out_written_q,
						avcc_anxb_pkg::SingleBeat);
				end
			end
		end
	end

	// A pending result always has at least one beat to go.
	a_cnt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_cnt_q != '0))
		else $error("result register valid with no beats left");

	// No new byte enters while start code beats are still queued behind the
	// one on the port.
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !last_beat) |-> !pkt.ready)
		else $error("input taken while a start code burst is pending");

	// Only single-beat results may carry an error, and an error ends a packet.
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_err_q) |-> (out_eop_q && last_beat && !out_sc_q))
		else $error("error beat is not a lone end-of-packet beat");

	// An empty packet gives an error beat in the next cycle.
	a_empty_pkt: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && pkt.packet_start && pkt.packet_size == '0) |=>
		(out_valid_q && out_err_q && out_written_q == '0))
		else $error("empty packet did not give an error beat");

	// A start code burst never ends a packet.
	a_sc_no_eop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_sc_q) |-> !out_eop_q)
		else $error("start code beat marked as end of packet");

endmodule
